>>> rtl/core/rrsd_pkg.sv
// package for the rrip replacement core with stream detection and set dueling
// holds default sizes, fixed constants and the sequencer state type
// no dependencies
`default_nettype none
package rrsd_pkg;
    localparam int SET_COUNT_DEF     = 2048;
    localparam int WAY_COUNT_DEF     = 16;
    localparam int LEADER_COUNT_DEF  = 32;
    localparam int HISTORY_DEPTH_DEF = 4;
    localparam int RRPV_WIDTH_DEF    = 2;
    localparam int DUEL_WIDTH_DEF    = 10;

    localparam int ADDR_W     = 64;
    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int PERIOD_W   = 16;
    localparam int LFSR_W     = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd8192;
    localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'h0001;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
    localparam logic [4:0]          BRRIP_MASK   = 5'h1F;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_DECAY
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/rrsd_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module rrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/core/rrip_replacement_stream_dueling_core.sv
// top level of the rrip replacement core: sequencer, stream detector, dueling
// depends on rrsd_pkg and rrsd_ram
`default_nettype none
// Replacement policy engine for a set-associative cache. Raise start with a
// beat while busy is low. A victim query (op 0) returns its way on
// o_victim_way with o_victim_valid high for one cycle; the receiver
// cannot stall it, and the next beat may be taken in that same cycle. An
// update (op 1) returns nothing: the set rows are read, the address delta
// is formed, and the rows are written back. Every decay period an update is
// followed by a sweep that clears the reuse bits of the other sets, one set
// a cycle, during which busy stays high. After reset the core stays busy
// while it sets all RRPV rows to ones and clears the reuse and stream rows.
// i_cfg_wdata sets the decay period and may be written whenever the core idles.
module rrip_replacement_stream_dueling_core #(
    parameter int SET_COUNT     = rrsd_pkg::SET_COUNT_DEF,
    parameter int WAY_COUNT     = rrsd_pkg::WAY_COUNT_DEF,
    parameter int LEADER_COUNT  = rrsd_pkg::LEADER_COUNT_DEF,
    parameter int HISTORY_DEPTH = rrsd_pkg::HISTORY_DEPTH_DEF,
    parameter int RRPV_WIDTH    = rrsd_pkg::RRPV_WIDTH_DEF,
    parameter int DUEL_WIDTH    = rrsd_pkg::DUEL_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_op,
    input  wire logic [rrsd_pkg::SET_IN_W-1:0]     i_set_index,
    input  wire logic [rrsd_pkg::WAY_IN_W-1:0]     i_way_index,
    input  wire logic [rrsd_pkg::ADDR_W-1:0]       i_phys_address,
    input  wire logic                              i_was_hit,
    output logic                                   o_victim_valid,
    output logic      [rrsd_pkg::WAY_IN_W-1:0]     o_victim_way,
    input  wire logic                              i_cfg_we,
    input  wire logic [rrsd_pkg::PERIOD_W-1:0]     i_cfg_wdata
);
    import rrsd_pkg::*;

    localparam int SW     = $clog2(SET_COUNT);
    localparam int WW     = $clog2(WAY_COUNT);
    localparam int HW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int RROW_W = WAY_COUNT * RRPV_WIDTH;
    localparam int SROW_W = ADDR_W * (HISTORY_DEPTH + 1) + HW + 1;
    localparam int HIST_LO = ADDR_W;
    localparam int SLOT_LO = ADDR_W * (HISTORY_DEPTH + 1);
    localparam int FLAG_B  = SLOT_LO + HW;
    localparam logic [RRPV_WIDTH-1:0] RMAX  = {RRPV_WIDTH{1'b1}};
    localparam logic [RRPV_WIDTH-1:0] RNEAR = RMAX - 1'b1;
    localparam logic [DUEL_WIDTH-1:0] DMAX  = {DUEL_WIDTH{1'b1}};
    localparam logic [DUEL_WIDTH-1:0] DMID  = DUEL_WIDTH'(1) << (DUEL_WIDTH - 1);
    localparam logic [SW-1:0] SET_LAST   = SW'(SET_COUNT - 1);
    localparam logic [SW-1:0] LEAD_LO    = SW'(LEADER_COUNT);
    localparam logic [SW-1:0] LEAD_HI    = SW'(SET_COUNT - LEADER_COUNT);
    localparam logic [HW-1:0] SLOT_LAST  = HW'(HISTORY_DEPTH - 1);

    t_state r_state, n_state;
    logic [SW-1:0]          r_sweep, n_sweep;
    logic [SW-1:0]          r_set, n_set;
    logic [WW-1:0]          r_way, n_way;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic                   r_op, n_op;
    logic                   r_hit, n_hit;
    logic [ADDR_W-1:0]      r_delta, n_delta;
    logic [DUEL_WIDTH-1:0]  r_duel, n_duel;
    logic [PERIOD_W-1:0]    r_decay, n_decay;
    logic [LFSR_W-1:0]      r_lfsr, n_lfsr;
    logic [PERIOD_W-1:0]    r_period;
    logic                   r_vld, n_vld;
    logic [WW-1:0]          r_victim, n_victim;

    logic [SW-1:0]     w_addr;
    logic              w_rwe, w_uwe, w_swe;
    logic [RROW_W-1:0] w_rwdata, w_rrow;
    logic [WAY_COUNT-1:0] w_uwdata, w_urow;
    logic [SROW_W-1:0] w_swdata, w_srow;

    rrsd_ram #(.WIDTH(RROW_W), .DEPTH(SET_COUNT)) u_rrpv_ram (
        .i_clk(i_clk), .i_we(w_rwe), .i_addr(w_addr), .i_wdata(w_rwdata), .o_rdata(w_rrow)
    );
    rrsd_ram #(.WIDTH(WAY_COUNT), .DEPTH(SET_COUNT)) u_reuse_ram (
        .i_clk(i_clk), .i_we(w_uwe), .i_addr(w_addr), .i_wdata(w_uwdata), .o_rdata(w_urow)
    );
    rrsd_ram #(.WIDTH(SROW_W), .DEPTH(SET_COUNT)) u_stream_ram (
        .i_clk(i_clk), .i_we(w_swe), .i_addr(w_addr), .i_wdata(w_swdata), .o_rdata(w_srow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_sweep  <= '0;
            r_duel   <= DMID;
            r_decay  <= '0;
            r_lfsr   <= LFSR_SEED;
            r_period <= PERIOD_RESET;
            r_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_duel  <= n_duel;
            r_decay <= n_decay;
            r_lfsr  <= n_lfsr;
            r_vld   <= n_vld;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_set    <= n_set;
        r_way    <= n_way;
        r_addr   <= n_addr;
        r_op     <= n_op;
        r_hit    <= n_hit;
        r_delta  <= n_delta;
        r_victim <= n_victim;
    end

    // victim search over the row just read
    logic                 w_stream;
    logic                 w_dead_f, w_max_f, w_near_f;
    logic [WW-1:0]        w_dead_w, w_max_w, w_near_w;
    logic [RROW_W-1:0]    w_aged;
    logic [RRPV_WIDTH-1:0] w_rv;

    always_comb begin
        w_stream = w_srow[FLAG_B];
        w_dead_f = 1'b0; w_max_f = 1'b0; w_near_f = 1'b0;
        w_dead_w = '0;   w_max_w = '0;   w_near_w = '0;
        w_aged   = w_rrow;
        w_rv     = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            w_rv = w_rrow[w*RRPV_WIDTH +: RRPV_WIDTH];
            if (w_rv == RMAX && !w_urow[w]) begin
                w_dead_f = 1'b1; w_dead_w = WW'(w);
            end
            if (w_rv == RMAX) begin
                w_max_f = 1'b1; w_max_w = WW'(w);
            end else begin
                w_aged[w*RRPV_WIDTH +: RRPV_WIDTH] = w_rv + 1'b1;
            end
            if (w_rv == RNEAR) begin
                w_near_f = 1'b1; w_near_w = WW'(w);
            end
        end
    end

    // stream detector on the new history
    logic [ADDR_W*HISTORY_DEPTH-1:0] w_hist;
    logic [HW-1:0]         w_slot, w_slot_nx;
    logic                  w_new_stream;

    always_comb begin
        w_hist = w_srow[HIST_LO +: ADDR_W*HISTORY_DEPTH];
        w_slot = w_srow[SLOT_LO +: HW];
        for (int h = 0; h < HISTORY_DEPTH; h++) begin
            if (w_slot == HW'(h)) begin
                w_hist[h*ADDR_W +: ADDR_W] = r_delta;
            end
        end
        w_slot_nx = (w_slot == SLOT_LAST) ? '0 : w_slot + 1'b1;
        w_new_stream = (w_hist[ADDR_W-1:0] != '0);
        for (int h = 1; h < HISTORY_DEPTH; h++) begin
            if (w_hist[h*ADDR_W +: ADDR_W] != w_hist[ADDR_W-1:0]) begin
                w_new_stream = 1'b0;
            end
        end
    end

    // fill policy and decay period check
    logic                  w_srrip_lead, w_brrip_lead, w_use_srrip;
    logic [LFSR_W-1:0]     w_lfsr_nx;
    logic [RRPV_WIDTH-1:0] w_fill;
    logic [PERIOD_W-1:0]   w_decay_inc;
    logic                  w_decay_hit;

    always_comb begin
        w_srrip_lead = r_set < LEAD_LO;
        w_brrip_lead = !w_srrip_lead && r_set >= LEAD_HI;
        w_use_srrip  = w_srrip_lead || (!w_brrip_lead && r_duel >= DMID);
        w_lfsr_nx    = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
        if (r_hit) begin
            w_fill = '0;
        end else if (w_new_stream) begin
            w_fill = RMAX;
        end else if (w_use_srrip || (w_lfsr_nx[4:0] & BRRIP_MASK) == '0) begin
            w_fill = RNEAR;
        end else begin
            w_fill = RMAX;
        end
        w_decay_inc = r_decay + 1'b1;
        w_decay_hit = (w_decay_inc == '0) || (w_decay_inc >= r_period);
    end

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_set    = r_set;
        n_way    = r_way;
        n_addr   = r_addr;
        n_op     = r_op;
        n_hit    = r_hit;
        n_delta  = r_delta;
        n_duel   = r_duel;
        n_decay  = r_decay;
        n_lfsr   = r_lfsr;
        n_vld    = 1'b0;
        n_victim = r_victim;
        busy     = (r_state != ST_IDLE);
        w_addr   = r_set;
        w_rwe = 1'b0; w_uwe = 1'b0; w_swe = 1'b0;
        w_rwdata = w_aged;
        w_uwdata = '0;
        w_swdata = '0;

        case (r_state)
            ST_CLEAR: begin
                w_addr   = r_sweep;
                w_rwe = 1'b1; w_uwe = 1'b1; w_swe = 1'b1;
                w_rwdata = {RROW_W{1'b1}};
                n_sweep  = r_sweep + 1'b1;
                if (r_sweep == SET_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_addr = SW'(i_set_index);
                if (start) begin
                    n_set   = SW'(i_set_index);
                    n_way   = WW'(i_way_index);
                    n_addr  = i_phys_address;
                    n_op    = i_op;
                    n_hit   = i_was_hit;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_op == OP_QUERY) begin
                    n_vld   = 1'b1;
                    n_state = ST_IDLE;
                    if (!w_stream && w_dead_f) begin
                        n_victim = w_dead_w;
                    end else if (w_max_f) begin
                        n_victim = w_max_w;
                    end else begin
                        // no way at max: age the set and return the first way at the near value, else way 0
                        w_rwe    = 1'b1;
                        n_victim = w_near_f ? w_near_w : '0;
                    end
                end else begin
                    n_delta = (w_srow[ADDR_W-1:0] == '0) ? '0
                              : r_addr - w_srow[ADDR_W-1:0];
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_rwe = 1'b1; w_uwe = 1'b1; w_swe = 1'b1;
                w_rwdata = w_rrow;
                w_rwdata[r_way*RRPV_WIDTH +: RRPV_WIDTH] = w_fill;
                w_uwdata = w_decay_hit ? '0 : w_urow;
                w_uwdata[r_way] = r_hit;
                w_swdata = {w_new_stream, w_slot_nx, w_hist, r_addr};
                if (!r_hit && !w_new_stream) begin
                    if (!w_use_srrip) begin
                        n_lfsr = w_lfsr_nx;
                    end
                    if (w_srrip_lead && r_duel != DMAX) begin
                        n_duel = r_duel + 1'b1;
                    end else if (w_brrip_lead && r_duel != '0) begin
                        n_duel = r_duel - 1'b1;
                    end
                end
                if (w_decay_hit) begin
                    n_decay = '0;
                    n_sweep = '0;
                    n_state = ST_DECAY;
                end else begin
                    n_decay = w_decay_inc;
                    n_state = ST_IDLE;
                end
            end
            ST_DECAY: begin
                // the updated set already holds its fresh reuse bits
                w_addr  = r_sweep;
                w_uwe   = (r_sweep != r_set);
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == SET_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_victim_valid = r_vld;
    assign o_victim_way   = WAY_IN_W'(r_victim);

    a_vld_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> $past(r_state == ST_READ && r_op == OP_QUERY))
        else $error("victim beat without a query read");
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_READ))
        else $error("accepted beat did not start a read");
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> $past(r_state == ST_READ))
        else $error("write-back without a preceding read");
    a_decay_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECAY && $past(r_state == ST_WRITE)) |-> (r_decay == '0))
        else $error("decay count not cleared at sweep");
endmodule
`default_nettype wire
